FILE: hw/rtl/oulmtf_pkg.sv
`default_nettype none
package oulmtf_pkg;

	localparam int CMD_W      = 3;
	localparam int KEY_PORT_W = 32;
	localparam int POS_W      = 7;
	localparam int STATUS_W   = 3;
	localparam int POS_MAX_W  = 11;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT_AT  = 3'd0,
		CMD_INSERT_TOP = 3'd1,
		CMD_INSERT_BOT = 3'd2,
		CMD_REMOVE_AT  = 3'd3,
		CMD_REMOVE_KEY = 3'd4,
		CMD_FIND       = 3'd5,
		CMD_MOVE_TOP   = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE       = 3'd0,
		ST_BAD_OFFSET = 3'd1,
		ST_FULL       = 3'd2,
		ST_DUPLICATE  = 3'd3,
		ST_NO_CHANGE  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_MATCH,
		OP_INSERT,
		OP_REMOVE,
		OP_MOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [POS_MAX_W-1:0]   where;
		logic [POS_MAX_W-1:0]   limit;
	} cell_ctrl_t;

	typedef struct packed {
		logic [CMD_W-1:0]      command;
		logic [KEY_PORT_W-1:0] item_key;
		logic [POS_W-1:0]      offset;
	} cmd_item_t;

	typedef struct packed {
		logic [POS_W-1:0]    position;
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    entry_count;
	} rsp_item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/oulmtf_if.sv
`default_nettype none
interface oulmtf_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/oulmtf_cell.sv
`default_nettype none
module oulmtf_cell #(
	parameter int INDEX     = 0,
	parameter int KEY_WIDTH = 32
) (
	input  wire                        clk,
	input  oulmtf_pkg::cell_ctrl_t     ctrl,
	input  wire  [KEY_WIDTH-1:0]       key,
	input  wire  [KEY_WIDTH-1:0]       up_key,
	input  wire  [KEY_WIDTH-1:0]       down_key,
	output logic [KEY_WIDTH-1:0]       entry,
	output logic                       match
);
	import oulmtf_pkg::*;

	localparam logic [POS_MAX_W-1:0] MY_POS = POS_MAX_W'(INDEX);

	logic [KEY_WIDTH-1:0] entry_q;
	logic                 match_q;
	logic [KEY_WIDTH-1:0] entry_d;

	always_comb begin
		entry_d = entry_q;
		case (ctrl.op)
			OP_INSERT: begin
				if (MY_POS == ctrl.where) begin
					entry_d = key;
				end else if (MY_POS > ctrl.where) begin
					entry_d = up_key;
				end
			end
			OP_REMOVE: begin
				if (MY_POS >= ctrl.where) begin
					entry_d = down_key;
				end
			end
			OP_MOVE: begin
				if (MY_POS == '0) begin
					entry_d = key;
				end else if (MY_POS <= ctrl.where) begin
					entry_d = up_key;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
		if (ctrl.op == OP_MATCH) begin
			match_q <= (MY_POS < ctrl.limit) && (entry_q == key);
		end
	end

	assign entry = entry_q;
	assign match = match_q;
endmodule
`default_nettype wire

FILE: hw/rtl/ordered_unique_list_move_to_front_core.sv
// Ordered list of unique keys with move-to-front, held in a row of cells.
// Commands arrive on the cmd channel and each produces exactly one result
// transaction on the rsp channel carrying position, status and entry count.
// A command is taken; in the next cycle every cell compares its key with
// the command key and registers a match bit; in the following cycle the
// match vector is encoded and the command is decided, and once the output
// register is free or being read, every cell loads, holds or takes its
// neighbor's key and the result is written into the output register.
// The next command is taken in the same cycle as the result is written, so
// commands follow one another through the compare cycle and then the
// shift cycle over the cell row, with no idle state between them.
// The result sits in an output register; when the receiver stalls, the
// block still takes one more command and compares it, then holds in the
// shift cycle until the waiting result has been taken.
// Reset clears the entry count and the handshake state; cell contents are
// not cleared, since only cells below the count can ever report a match.
`default_nettype none
module ordered_unique_list_move_to_front_core #(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 32
) (
	input  wire       clk,
	input  wire       arst_n,
	oulmtf_if.sink    cmd,
	oulmtf_if.source  rsp
);
	import oulmtf_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_APPLY
	} state_t;

	state_t               state_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [POS_W-1:0]     off_q;
	logic [CNT_W-1:0]     count_q;
	logic                 out_valid_q;
	rsp_item_t            out_q;

	logic                 finish;
	logic                 accept;
	cell_ctrl_t           ctrl;
	logic [CAPACITY-1:0]  match;
	logic [KEY_WIDTH-1:0] entry [CAPACITY];

	logic [IDX_W-1:0]     enc_pos;
	logic                 found;
	logic [CNT_W-1:0]     found_pos;
	logic [CMP_W-1:0]     off_ext;
	logic [CMP_W-1:0]     cnt_ext;
	logic                 full;
	cell_op_t             act_op;
	logic [POS_MAX_W-1:0] act_where;
	status_t              act_status;
	logic [CNT_W-1:0]     act_pos;
	logic [CNT_W-1:0]     act_count;

	assign finish = (state_q == ST_APPLY) && (!out_valid_q || rsp.ready);
	assign cmd.ready = (state_q == ST_IDLE) || finish;
	assign accept = cmd.valid && cmd.ready;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [KEY_WIDTH-1:0] up_key;
			logic [KEY_WIDTH-1:0] down_key;
			if (g == 0) begin : g_top
				assign up_key = key_q;
			end else begin : g_mid_up
				assign up_key = entry[g-1];
			end
			if (g == CAPACITY - 1) begin : g_bottom
				assign down_key = entry[g];
			end else begin : g_mid_down
				assign down_key = entry[g+1];
			end
			oulmtf_cell #(
				.INDEX     (g),
				.KEY_WIDTH (KEY_WIDTH)
			) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.key      (key_q),
				.up_key   (up_key),
				.down_key (down_key),
				.entry    (entry[g]),
				.match    (match[g])
			);
		end
	endgenerate

	always_comb begin
		enc_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match[i]) begin
				enc_pos = enc_pos | IDX_W'(i);
			end
		end
	end

	assign found     = |match;
	assign found_pos = found ? CNT_W'(enc_pos) : count_q;
	assign off_ext   = CMP_W'(off_q);
	assign cnt_ext   = CMP_W'(count_q);
	assign full      = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		act_op     = OP_HOLD;
		act_where  = '0;
		act_status = ST_NO_CHANGE;
		act_pos    = '0;
		act_count  = count_q;
		unique case (cmd_q)
			CMD_INSERT_AT, CMD_INSERT_TOP, CMD_INSERT_BOT: begin
				if (cmd_q == CMD_INSERT_AT) begin
					act_where = POS_MAX_W'(off_q);
				end else if (cmd_q == CMD_INSERT_BOT) begin
					act_where = POS_MAX_W'(count_q);
				end
				if (cmd_q == CMD_INSERT_AT && off_ext > cnt_ext) begin
					act_status = ST_BAD_OFFSET;
				end else if (found) begin
					act_status = ST_DUPLICATE;
				end else if (full) begin
					act_status = ST_FULL;
				end else begin
					act_status = ST_DONE;
					act_op     = OP_INSERT;
					act_count  = count_q + 1'b1;
				end
			end
			CMD_REMOVE_AT: begin
				act_where = POS_MAX_W'(off_q);
				if (off_ext < cnt_ext) begin
					act_status = ST_DONE;
					act_op     = OP_REMOVE;
					act_count  = count_q - 1'b1;
				end
			end
			CMD_REMOVE_KEY: begin
				act_where = POS_MAX_W'(found_pos);
				if (found) begin
					act_status = ST_DONE;
					act_op     = OP_REMOVE;
					act_count  = count_q - 1'b1;
				end
			end
			CMD_FIND: begin
				act_pos    = found_pos;
				act_status = ST_DONE;
			end
			CMD_MOVE_TOP: begin
				act_pos   = found_pos;
				act_where = POS_MAX_W'(found_pos);
				if (found) begin
					act_status = ST_DONE;
					act_op     = OP_MOVE;
				end
			end
			default: begin
				act_status = ST_NO_CHANGE;
			end
		endcase
	end

	always_comb begin
		ctrl.op    = OP_HOLD;
		ctrl.where = act_where;
		ctrl.limit = POS_MAX_W'(count_q);
		if (state_q == ST_MATCH) begin
			ctrl.op = OP_MATCH;
		end else if (finish) begin
			ctrl.op = act_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (finish) begin
						count_q           <= act_count;
						out_valid_q       <= 1'b1;
						out_q.position    <= POS_W'(act_pos);
						out_q.status      <= act_status;
						out_q.entry_count <= POS_W'(act_count);
						state_q           <= accept ? ST_MATCH : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd.payload.command;
			key_q <= KEY_WIDTH'(cmd.payload.item_key);
			off_q <= cmd.payload.offset;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_APPLY |-> $onehot0(match))
		else $error("key matched in more than one cell");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!finish |=> $stable(count_q))
		else $error("entry count changed outside the shift cycle");

	a_result_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_APPLY)
		else $error("result appeared without a shift cycle");

	a_accept_to_match: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_MATCH)
		else $error("accepted transaction did not enter the compare cycle");
endmodule
`default_nettype wire
